### design/packed_simd_alu_top_defines.svh
// Assertion macros for the packed SIMD ALU.
// Used by the top level; no other dependencies.
`ifndef PACKED_SIMD_ALU_TOP_DEFINES_SVH
`define PACKED_SIMD_ALU_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/psa_pkg.sv
// Shared types, action codes and constants for the packed SIMD ALU.
// No dependencies.
package psa_pkg;
    typedef enum logic [3:0] {
        ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_AND = 4'd3,
        ACT_OR  = 4'd4, ACT_XOR = 4'd5, ACT_NOT = 4'd6, ACT_SHL = 4'd7,
        ACT_SHR = 4'd8
    } action_t;

    localparam int NUM_LANES = 16;   // byte lanes over 128 bits

    typedef struct packed {
        logic [3:0] action;
        logic [3:0] lane_bytes;      // one-hot: 8,4,2,1
        logic [4:0] vec_bytes;
        logic       bad;
    } ctl_t;

    // Packed from the top bit down, so result_low lands in the lowest bits.
    typedef struct packed {
        logic        not_a_result;
        logic [4:0]  result_vector_bytes;
        logic [3:0]  result_lane_bytes;
        logic [63:0] result_high;
        logic [63:0] result_low;
    } res_t;

    localparam int RES_W = 138;
    localparam int IN_W  = 280;
endpackage

### design/psa_lane.sv
// One 64-bit lane unit: applies the action at a lane width of 1, 2, 4 or 8 bytes.
// Depends on psa_pkg. Multiplies are registered before the merge stage.
module psa_lane (
    input  logic              aclk,
    input  logic              en,
    input  psa_pkg::ctl_t     ctl,
    input  logic [63:0]       x,
    input  logic [63:0]       y,
    output logic [63:0]       r_reg
);
    import psa_pkg::*;

    logic [63:0] r_next;
    logic [63:0] r8, r16, r32, r64;

    function automatic logic [63:0] lop(input logic [3:0] act, input logic [63:0] a,
                                        input logic [63:0] b, input int bits,
                                        input logic ar);
        logic [63:0] m, r;
        logic        neg;
        m   = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        neg = ar && a[bits-1];
        r   = '0;
        case (act)
            ACT_ADD: r = (a + b) & m;
            ACT_SUB: r = (a - b) & m;
            // Low 64 bits of the product from 32x32 partial products.
            ACT_MUL: r = (64'(a[31:0]) * 64'(b[31:0])
                          + {a[31:0] * b[63:32] + a[63:32] * b[31:0], 32'd0}) & m;
            ACT_SHL: r = (b >= 64'(bits)) ? '0 : ((a << b[5:0]) & m);
            ACT_SHR: begin
                if (b >= 64'(bits)) r = neg ? m : '0;
                else begin
                    r = a >> b[5:0];
                    if (neg) r = r | (m & ~(m >> b[5:0]));
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        for (int i = 0; i < 8; i++)
            r8[i*8 +: 8] = 8'(lop(ctl.action, 64'(x[i*8 +: 8]), 64'(y[i*8 +: 8]), 8, 1'b0));
        for (int i = 0; i < 4; i++)
            r16[i*16 +: 16] = 16'(lop(ctl.action, 64'(x[i*16 +: 16]), 64'(y[i*16 +: 16]),
                                      16, 1'b1));
        for (int i = 0; i < 2; i++)
            r32[i*32 +: 32] = 32'(lop(ctl.action, 64'(x[i*32 +: 32]), 64'(y[i*32 +: 32]),
                                      32, 1'b1));
        r64 = lop(ctl.action, x, y, 64, 1'b0);
        case (ctl.action)
            ACT_AND: r_next = x & y;
            ACT_OR:  r_next = x | y;
            ACT_XOR: r_next = x ^ y;
            ACT_NOT: r_next = ~x;
            default: begin
                case (ctl.lane_bytes)
                    4'b0001: r_next = r8;
                    4'b0010: r_next = r16;
                    4'b0100: r_next = r32;
                    default: r_next = r64;
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) r_reg <= r_next;
    end
endmodule

### design/psa_merge.sv
// Merge stage: joins the two lane halves, masks to vector width, flags bad tags.
// Depends on psa_pkg.
module psa_merge (
    input  psa_pkg::ctl_t  ctl,
    input  logic [63:0]    lo,
    input  logic [63:0]    hi,
    output psa_pkg::res_t  res
);
    import psa_pkg::*;

    logic [63:0] m;

    always_comb begin
        case (ctl.vec_bytes)
            5'd1:    m = 64'h0000_0000_0000_00FF;
            5'd2:    m = 64'h0000_0000_0000_FFFF;
            5'd4:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        if (ctl.bad) begin
            res = '{result_low: 64'd0, result_high: 64'd0, result_lane_bytes: 4'd1,
                    result_vector_bytes: 5'd1, not_a_result: 1'b1};
        end else begin
            res.result_low          = lo & m;
            res.result_high         = (ctl.vec_bytes == 5'd16) ? hi : 64'd0;
            res.result_lane_bytes   = ctl.lane_bytes;
            res.result_vector_bytes = ctl.vec_bytes;
            res.not_a_result        = 1'b0;
        end
    end
endmodule

### design/packed_simd_alu_top.sv
// Packed SIMD ALU top level: decode, two 64-bit lane units, merge and output register.
// Depends on psa_pkg, psa_lane, psa_merge and packed_simd_alu_top_defines.svh.
//
// A 128-bit packed integer ALU. Each transfer on the s_ side carries one
// operation and two tagged operands; exactly one result transfer follows on
// the m_ side. The block is a two-stage pipeline: the lane units compute and
// register each 64-bit half (the multiply sets the stage timing), then the
// merge stage masks to vector width and fills the output register. The result
// is valid once it has passed the lane and output registers, and a new item is
// taken every cycle while the result side keeps up. The pipeline advances as a
// whole when the output register is empty or being drained, so stalls on the
// m_ side hold every stage. Bad tags, illegal widths or unknown actions give a
// not-a-result with zero value and widths of one.
`include "packed_simd_alu_top_defines.svh"
module packed_simd_alu_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[3:0], a_low[67:4], a_high[131:68], a_lane_bytes[136:132],
    // a_vector_bytes[141:137], b_low[205:142], b_high[269:206],
    // b_lane_bytes[274:270], b_vector_bytes[279:275]
    input  logic [279:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_low[63:0], result_high[127:64], result_lane_bytes[131:128],
    // result_vector_bytes[136:132], not_a_result[137], zeros above
    output logic [143:0] m_tdata
);
    import psa_pkg::*;

    logic [3:0]  act;
    logic [63:0] al, ah, bl, bh;
    logic [4:0]  alb, avb, blb, bvb;
    logic        bad, adv;
    ctl_t        ctl_in, ctl_reg;
    logic        v1_reg, v2_reg;
    logic [63:0] lo_reg, hi_reg;
    res_t        res, out_reg;
    logic        out_nar, out_zero;

    assign act = s_tdata[3:0];
    assign al  = s_tdata[67:4];
    assign ah  = s_tdata[131:68];
    assign alb = s_tdata[136:132];
    assign avb = s_tdata[141:137];
    assign bl  = s_tdata[205:142];
    assign bh  = s_tdata[269:206];
    assign blb = s_tdata[274:270];
    assign bvb = s_tdata[279:275];

    // Advance the whole pipe when the output is free or being drained.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb begin
        bad = (act > ACT_SHR);
        if (act != ACT_NOT && (alb != blb || avb != bvb)) bad = 1'b1;
        if (!(alb == 5'd1 || alb == 5'd2 || alb == 5'd4 || alb == 5'd8)) bad = 1'b1;
        if (!(avb == 5'd1 || avb == 5'd2 || avb == 5'd4 || avb == 5'd8 || avb == 5'd16))
            bad = 1'b1;
        ctl_in.action     = act;
        ctl_in.lane_bytes = alb[3:0];
        ctl_in.vec_bytes  = avb;
        ctl_in.bad        = bad;
    end

    psa_lane u_lo (.aclk(aclk), .en(adv), .ctl(ctl_in), .x(al), .y(bl), .r_reg(lo_reg));
    psa_lane u_hi (.aclk(aclk), .en(adv), .ctl(ctl_in), .x(ah), .y(bh), .r_reg(hi_reg));

    psa_merge u_merge (.ctl(ctl_reg), .lo(lo_reg), .hi(hi_reg), .res(res));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
        if (adv) begin
            ctl_reg <= ctl_in;
            out_reg <= res;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = {6'd0, out_reg};

    assign out_nar  = out_reg.not_a_result;
    assign out_zero = (out_reg.result_low == 64'd0) && (out_reg.result_high == 64'd0);

    `PSA_ASSERT_IMPL(a_nar_zero, aclk, aresetn, m_tvalid && out_nar, out_zero)
    `PSA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(out_reg))
    `PSA_ASSERT_NEXT(a_flow, aclk, aresetn, adv && v1_reg, m_tvalid)
endmodule

### bench/tb.sv
// Testbench for the packed SIMD ALU: directed and random lane operations checked against
// an in-bench lane predictor. Depends on psa_pkg and packed_simd_alu_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psa_pkg::*;

    localparam logic [3:0] ACT_FIRST_BAD = 4'd9;
    localparam logic [3:0] ACT_LAST_BAD  = 4'd15;

    typedef struct {
        logic [3:0]  action;
        logic [63:0] a_low, a_high;
        logic [4:0]  a_lane, a_vec;
        logic [63:0] b_low, b_high;
        logic [4:0]  b_lane, b_vec;
    } alu_req_t;

    typedef struct {
        logic [63:0] lo, hi;
        logic [3:0]  lane;
        logic [4:0]  vec;
        logic        nar;
    } alu_rsp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [279:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    alu_rsp_t pending_results[$];
    int       errors = 0;
    bit       no_idle = 1'b0;   // suppress random gaps on both sides
    int       hold_off = 0;     // cycles the receiver must still refuse

    always #2 aclk = ~aclk;

    packed_simd_alu_top u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata
    );

    function automatic logic [63:0] lmask(int bits);
        return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    endfunction

    // Compute one lane; count in y is the full lane value of b.
    function automatic logic [63:0] lane_calc(logic [3:0] act, logic [63:0] x, logic [63:0] y,
                                              int bits, bit arith);
        logic [63:0] m;
        logic [63:0] r;
        bit          neg;
        m = lmask(bits);
        case (act)
            ACT_ADD: return (x + y) & m;
            ACT_SUB: return (x - y) & m;
            ACT_MUL: return (x * y) & m;
            ACT_SHL: return (y >= bits) ? 64'd0 : ((x << y) & m);
            default: begin
                neg = arith && x[bits-1];
                if (y >= bits) return neg ? m : 64'd0;
                r = x >> y;
                if (neg) r |= m & ~(m >> y);
                return r;
            end
        endcase
    endfunction

    function automatic logic [63:0] half_calc(logic [3:0] act, logic [63:0] x, logic [63:0] y,
                                              int lbytes);
        int          bits;
        logic [63:0] m;
        logic [63:0] acc;
        bits = lbytes * 8;
        m = lmask(bits);
        acc = '0;
        for (int i = 0; i < 64 / bits; i++)
            acc |= lane_calc(act, (x >> (i * bits)) & m, (y >> (i * bits)) & m, bits,
                             lbytes == 2 || lbytes == 4) << (i * bits);
        return acc;
    endfunction

    function automatic alu_rsp_t predict_alu(alu_req_t q);
        alu_rsp_t r;
        bit       bad;
        bad = q.action > ACT_SHR;
        if (q.action != ACT_NOT && (q.a_lane != q.b_lane || q.a_vec != q.b_vec)) bad = 1;
        if (!(q.a_lane inside {1, 2, 4, 8})) bad = 1;
        if (!(q.a_vec inside {1, 2, 4, 8, 16})) bad = 1;
        r = '{lo: 0, hi: 0, lane: 1, vec: 1, nar: 1};
        if (bad) return r;
        case (q.action)
            ACT_AND: begin r.lo = q.a_low & q.b_low; r.hi = q.a_high & q.b_high; end
            ACT_OR:  begin r.lo = q.a_low | q.b_low; r.hi = q.a_high | q.b_high; end
            ACT_XOR: begin r.lo = q.a_low ^ q.b_low; r.hi = q.a_high ^ q.b_high; end
            ACT_NOT: begin r.lo = ~q.a_low; r.hi = ~q.a_high; end
            default: begin
                r.lo = half_calc(q.action, q.a_low, q.b_low, q.a_lane);
                r.hi = half_calc(q.action, q.a_high, q.b_high, q.a_lane);
            end
        endcase
        if (q.a_vec < 16) begin
            r.hi = 0;
            if (q.a_vec < 8) r.lo &= lmask(q.a_vec * 8);
        end
        r.lane = q.a_lane[3:0];
        r.vec = q.a_vec;
        r.nar = 0;
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then record the expectation.
    // Valid stays high after the transfer; the next call may drop it and drain drops it.
    task automatic send_item(alu_req_t q);
        while (!no_idle && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {q.b_vec, q.b_lane, q.b_high, q.b_low, q.a_vec, q.a_lane,
                    q.a_high, q.a_low, q.action};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_alu(q));
    endtask

    function automatic logic [4:0] pick_width(bit vec);
        int k;
        k = $urandom_range(vec ? 4 : 3);
        return 5'd1 << k;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic alu_req_t make_item(logic [3:0] act, logic [4:0] lane, logic [4:0] vec);
        alu_req_t q;
        q = '{action: act, a_low: rand64(), a_high: rand64(), a_lane: lane, a_vec: vec,
              b_low: rand64(), b_high: rand64(), b_lane: lane, b_vec: vec};
        return q;
    endfunction

    // Small shift counts so in-range shifts dominate, some oversized.
    function automatic logic [63:0] shift_counts(int lbytes);
        logic [63:0] v;
        int          bits;
        bits = lbytes * 8;
        v = '0;
        for (int i = 0; i < 64 / bits; i++)
            v |= (($urandom_range(9) == 0) ? (rand64() & lmask(bits))
                                           : 64'($urandom_range(bits))) << (i * bits);
        return v;
    endfunction

    task automatic test_directed();
        alu_req_t q;
        for (int act = 0; act <= 8; act++) begin
            q = make_item(4'(act), 5'd8, 5'd16);
            q.a_low = '1; q.b_low = '1; q.a_high = '0; q.b_high = 64'd1;
            send_item(q);
        end
        // Arithmetic shift right of negative 2- and 4-byte lanes, logical for 1 and 8.
        for (int i = 3; i >= 0; i--) begin
            q = make_item(ACT_SHR, 5'd1 << i, 5'd16);
            q.a_low = 64'h8000_8000_8000_8000; q.a_high = '1;
            q.b_low = 64'h0101_0101_0101_0101; q.b_high = '0;
            send_item(q);
        end
        // Oversized counts, both directions.
        q = make_item(ACT_SHL, 5'd4, 5'd16); q.b_low = '1; q.b_high = {2{32'd32}};
        send_item(q);
        q = make_item(ACT_SHR, 5'd4, 5'd16); q.a_low = '1; q.b_low = {2{32'd40}};
        send_item(q);
        // Narrow vector below lane width.
        send_item(make_item(ACT_ADD, 5'd8, 5'd1));
        // Tag mismatch on lane and on vector, then not with mismatched b.
        q = make_item(ACT_XOR, 5'd2, 5'd8); q.b_lane = 5'd4; send_item(q);
        q = make_item(ACT_OR, 5'd2, 5'd8); q.b_vec = 5'd16; send_item(q);
        q = make_item(ACT_NOT, 5'd1, 5'd4); q.b_lane = 5'd31; q.b_vec = 5'd0; send_item(q);
        // Illegal lane and vector widths, unknown actions up to the top code.
        q = make_item(ACT_ADD, 5'd3, 5'd8); send_item(q);
        q = make_item(ACT_ADD, 5'd16, 5'd31); send_item(q);
        send_item(make_item(ACT_FIRST_BAD, 5'd1, 5'd1));
        send_item(make_item(ACT_LAST_BAD, 5'd8, 5'd16));
    endtask

    task automatic test_random(int n);
        alu_req_t q;
        logic [4:0] lane;
        for (int k = 0; k < n; k++) begin
            lane = pick_width(0);
            q = make_item(4'($urandom_range(8)), lane, pick_width(1));
            if (q.action inside {ACT_SHL, ACT_SHR}) begin
                q.b_low = shift_counts(lane);
                q.b_high = shift_counts(lane);
            end
            case ($urandom_range(19))
                0: q.action = 4'($urandom_range(15));
                1: q.b_lane = 5'($urandom_range(31));
                2: q.b_vec = 5'($urandom_range(31));
                3: begin q.a_lane = 5'($urandom_range(31)); q.b_lane = q.a_lane; end
                4: begin q.a_vec = 5'($urandom_range(31)); q.b_vec = q.a_vec; end
                default: ;
            endcase
            send_item(q);
        end
    endtask

    // Stop the receiver for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        hold_off = 60;
        fork
            test_random(40);
        join
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    // Receiver readiness: random gaps, a gap-free stretch, and the hold-off.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 35);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        alu_rsp_t want;
        alu_rsp_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{lo: m_tdata[63:0], hi: m_tdata[127:64], lane: m_tdata[131:128],
                    vec: m_tdata[136:132], nar: m_tdata[137]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result lo=%h", $time, got.lo);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.lo !== want.lo) begin
                    $display("%0t: result_low exp %h got %h", $time, want.lo, got.lo);
                    errors++;
                end
                if (got.hi !== want.hi) begin
                    $display("%0t: result_high exp %h got %h", $time, want.hi, got.hi);
                    errors++;
                end
                if (got.lane !== want.lane) begin
                    $display("%0t: lane_bytes exp %0d got %0d", $time, want.lane, got.lane);
                    errors++;
                end
                if (got.vec !== want.vec) begin
                    $display("%0t: vector_bytes exp %0d got %0d", $time, want.vec, got.vec);
                    errors++;
                end
                if (got.nar !== want.nar) begin
                    $display("%0t: not_a_result exp %0b got %0b", $time, want.nar, got.nar);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(250);
        test_backpressure();
        no_idle = 1'b1;
        test_random(120);
        no_idle = 1'b0;
        test_random(220);
        drain();
        if (pending_results.size() == 0 && errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #400000;
        $display("tb: done, errors");
        $finish;
    end
endmodule

### packed_simd_alu_top.f
+incdir+design
design/psa_pkg.sv
design/psa_lane.sv
design/psa_merge.sv
design/packed_simd_alu_top.sv
bench/tb.sv
